// ----- rtl/fsp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Format spec parser package
// Shared types, codes and character helpers for the format spec parser.
// ----------------------------------------------------------------------------
package fsp_pkg;

  localparam int NUMBER_BITS_DEF    = 16;
  localparam int KEY_COUNT_BITS_DEF = 8;
  localparam int VALUE_W            = 16;

  // Parse phases
  localparam logic [3:0] PH_KEY   = 4'd0;
  localparam logic [3:0] PH_FIRST = 4'd1;
  localparam logic [3:0] PH_ALIGN = 4'd3;
  localparam logic [3:0] PH_SIGN  = 4'd4;
  localparam logic [3:0] PH_HASH  = 4'd5;
  localparam logic [3:0] PH_ZERO  = 4'd6;
  localparam logic [3:0] PH_WIDTH = 4'd7;
  localparam logic [3:0] PH_WDIG  = 4'd8;
  localparam logic [3:0] PH_DYN   = 4'd9;
  localparam logic [3:0] PH_DDIG  = 4'd10;
  localparam logic [3:0] PH_COMMA = 4'd11;
  localparam logic [3:0] PH_DOT   = 4'd12;
  localparam logic [3:0] PH_PDIG  = 4'd13;
  localparam logic [3:0] PH_PRES  = 4'd14;
  localparam logic [3:0] PH_DONE  = 4'd15;

  // Characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Alignment
  localparam logic [2:0] AL_NONE   = 3'd0;
  localparam logic [2:0] AL_LEFT   = 3'd1;
  localparam logic [2:0] AL_RIGHT  = 3'd2;
  localparam logic [2:0] AL_PAD    = 3'd3;
  localparam logic [2:0] AL_CENTER = 3'd4;

  // Sign
  localparam logic [1:0] SG_NONE  = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_MINUS = 2'd2;
  localparam logic [1:0] SG_SPACE = 2'd3;

  // Width mode
  localparam logic [1:0] WM_NONE    = 2'd0;
  localparam logic [1:0] WM_FIXED   = 2'd1;
  localparam logic [1:0] WM_DYN     = 2'd2;
  localparam logic [1:0] WM_DYN_IDX = 2'd3;

  // Precision mode
  localparam logic [1:0] PM_NONE     = 2'd0;
  localparam logic [1:0] PM_DIGITS   = 2'd1;
  localparam logic [1:0] PM_DIG_DOT  = 2'd2;
  localparam logic [1:0] PM_DOT_ONLY = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_EXTRA  = 2'd1;
  localparam logic [1:0] ERR_ALIGN2 = 2'd2;
  localparam logic [1:0] ERR_NUMBER = 2'd3;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  typedef struct packed {
    logic [7:0]  key_length;
    logic [7:0]  fill_char;
    logic [2:0]  align_mode;
    logic [1:0]  sign_mode;
    logic        base_prefix;
    logic [1:0]  width_mode;
    logic [15:0] width_value;
    logic        thousands_sep;
    logic [1:0]  precision_mode;
    logic [15:0] precision_value;
    logic [7:0]  presentation;
    logic [1:0]  error_code;
  } out_t;

  typedef struct packed {
    logic [7:0] fill;
    logic [2:0] align;
    logic [1:0] sign;
    logic       hash;
    logic [1:0] wmode;
    logic       comma;
    logic [1:0] pmode;
    logic [7:0] pres;
    logic [1:0] err;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    fill:  CH_SPACE,
    align: AL_NONE,
    sign:  SG_NONE,
    hash:  1'b0,
    wmode: WM_NONE,
    comma: 1'b0,
    pmode: PM_NONE,
    pres:  8'h00,
    err:   ERR_NONE
  };

  function automatic logic [2:0] align_code(input logic [7:0] c);
    logic [2:0] r;
    case (c)
      CH_LT:    r = AL_LEFT;
      CH_GT:    r = AL_RIGHT;
      CH_EQ:    r = AL_PAD;
      CH_CARET: r = AL_CENTER;
      default:  r = AL_NONE;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] sign_code(input logic [7:0] c);
    logic [1:0] r;
    case (c)
      CH_PLUS:  r = SG_PLUS;
      CH_MINUS: r = SG_MINUS;
      CH_SPACE: r = SG_SPACE;
      default:  r = SG_NONE;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_ZERO:CH_NINE]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/fsp_feed.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Format spec body step
// Advances the body phase machine by one character: each phase consumes the
// character or hands it to the next one. Holds one times-ten digit update.
// ----------------------------------------------------------------------------
module fsp_feed
  import fsp_pkg::*;
#(
  parameter int NUMBER_BITS = NUMBER_BITS_DEF
) (
  input  wire logic [7:0]             ch,
  input  wire logic [3:0]             phase_i,
  input  wire flags_t                 flags_i,
  input  wire logic [NUMBER_BITS-1:0] accum_i,
  input  wire logic [NUMBER_BITS-1:0] wval_i,
  input  wire logic [NUMBER_BITS-1:0] pval_i,
  output logic      [3:0]             phase_o,
  output flags_t                      flags_o,
  output logic      [NUMBER_BITS-1:0] accum_o,
  output logic      [NUMBER_BITS-1:0] wval_o,
  output logic      [NUMBER_BITS-1:0] pval_o
);

  localparam int EXT_W = NUMBER_BITS + 4;
  localparam logic [EXT_W-1:0] NUM_MAX_EXT = EXT_W'({NUMBER_BITS{1'b1}});

  logic [EXT_W-1:0]       acc_ext;
  logic [EXT_W-1:0]       cont_ext;
  logic                   cont_ovf;
  logic [NUMBER_BITS-1:0] cont_val;
  logic [NUMBER_BITS-1:0] fresh_val;
  logic                   dig;
  logic [2:0]             al;
  logic [1:0]             sg;
  logic [3:0]             ph;
  logic                   done;

  assign acc_ext   = EXT_W'(accum_i);
  assign cont_ext  = (acc_ext << 3) + (acc_ext << 1) + EXT_W'(ch[3:0]);
  assign cont_ovf  = cont_ext > NUM_MAX_EXT;
  assign cont_val  = cont_ovf ? {NUMBER_BITS{1'b1}} : cont_ext[NUMBER_BITS-1:0];
  assign fresh_val = NUMBER_BITS'(ch[3:0]);
  assign dig       = is_digit(ch);
  assign al        = align_code(ch);
  assign sg        = sign_code(ch);

  always_comb begin
    ph      = phase_i;
    flags_o = flags_i;
    accum_o = accum_i;
    wval_o  = wval_i;
    pval_o  = pval_i;
    done    = (flags_i.err != ERR_NONE);

    if (!done && ph == PH_ALIGN) begin
      ph = PH_SIGN;
      if (al != AL_NONE) begin
        flags_o.align = al;
        done = 1'b1;
      end
    end

    if (!done && ph == PH_SIGN) begin
      ph = PH_HASH;
      if (sg != SG_NONE) begin
        flags_o.sign = sg;
        done = 1'b1;
      end
    end

    if (!done && ph == PH_HASH) begin
      ph = PH_ZERO;
      if (ch == CH_HASH) begin
        flags_o.hash = 1'b1;
        done = 1'b1;
      end
    end

    if (!done && ph == PH_ZERO) begin
      ph = PH_WIDTH;
      if (ch == CH_ZERO) begin
        done = 1'b1;
        if (flags_o.align != AL_NONE) begin
          flags_o.err = ERR_ALIGN2;
        end else begin
          flags_o.fill  = CH_ZERO;
          flags_o.align = AL_PAD;
        end
      end
    end

    if (!done && ph == PH_WIDTH) begin
      if (ch == CH_STAR) begin
        flags_o.wmode = WM_DYN;
        ph = PH_DYN;
        done = 1'b1;
      end else if (dig) begin
        flags_o.wmode = WM_FIXED;
        accum_o = fresh_val;
        wval_o  = fresh_val;
        ph = PH_WDIG;
        done = 1'b1;
      end else begin
        ph = PH_COMMA;
      end
    end

    if (!done && (ph inside {PH_WDIG, PH_DDIG})) begin
      if (dig) begin
        accum_o = cont_val;
        wval_o  = cont_val;
        if (cont_ovf) flags_o.err = ERR_NUMBER;
        done = 1'b1;
      end else begin
        ph = PH_COMMA;
      end
    end

    if (!done && ph == PH_DYN) begin
      if (dig) begin
        flags_o.wmode = WM_DYN_IDX;
        accum_o = fresh_val;
        wval_o  = fresh_val;
        ph = PH_DDIG;
        done = 1'b1;
      end else begin
        ph = PH_COMMA;
      end
    end

    if (!done && ph == PH_COMMA) begin
      ph = PH_DOT;
      if (ch == CH_COMMA) begin
        flags_o.comma = 1'b1;
        done = 1'b1;
      end
    end

    if (!done && ph == PH_DOT) begin
      if (ch == CH_DOT) begin
        flags_o.pmode = PM_DOT_ONLY;
        accum_o = '0;
        ph = PH_PDIG;
        done = 1'b1;
      end else begin
        ph = PH_PRES;
      end
    end

    if (!done && ph == PH_PDIG) begin
      if (dig) begin
        flags_o.pmode = PM_DIGITS;
        accum_o = cont_val;
        pval_o  = cont_val;
        if (cont_ovf) flags_o.err = ERR_NUMBER;
        done = 1'b1;
      end else begin
        ph = PH_PRES;
        if (flags_o.pmode == PM_DIGITS && ch == CH_DOT) begin
          flags_o.pmode = PM_DIG_DOT;
          done = 1'b1;
        end
      end
    end

    if (!done && ph == PH_PRES) begin
      flags_o.pres = ch;
      ph = PH_DONE;
      done = 1'b1;
    end

    if (!done && ph == PH_DONE) begin
      flags_o.err = ERR_EXTRA;
    end

    phase_o = ph;
  end

endmodule
`default_nettype wire

// ----- rtl/format_spec_parser.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Format spec parser
// Streaming parser for one argument specifier, one character per request.
// ----------------------------------------------------------------------------
// One character is taken every clock cycle, except while a last request is held
// as told below: the key counter, the one-character fill look-ahead and the body
// phase step with its times-ten accumulator are all combinational ahead of the
// state registers. The request flagged last returns its record in the output
// register on the next cycle. A last request waits only while a previous record
// sits unclaimed in that register; other characters keep flowing meanwhile.
// After each record the parser is back in its start state.
module format_spec_parser
  import fsp_pkg::*;
#(
  parameter int NUMBER_BITS    = NUMBER_BITS_DEF,
  parameter int KEY_COUNT_BITS = KEY_COUNT_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output out_t      out_data
);

  localparam logic [KEY_COUNT_BITS-1:0] KEY_MAX = '1;

  logic [3:0]                phase_r, phase_nxt, s_phase;
  logic                      pend_r, pend_nxt, s_pend;
  logic [7:0]                la_r, la_nxt, s_la;
  flags_t                    flags_r, flags_nxt, s_flags;
  logic [NUMBER_BITS-1:0]    acc_r, acc_nxt, s_acc;
  logic [NUMBER_BITS-1:0]    wval_r, wval_nxt, s_wval;
  logic [NUMBER_BITS-1:0]    pval_r, pval_nxt, s_pval;
  logic [KEY_COUNT_BITS-1:0] key_r, key_nxt, s_key;
  logic                      out_valid_r, out_valid_nxt;
  out_t                      out_data_r, out_data_nxt;

  logic [3:0]             f_phase_in, f_phase;
  flags_t                 f_flags;
  logic [NUMBER_BITS-1:0] f_acc, f_wval, f_pval;
  logic                   accept, finish;
  logic [2:0]             al;
  logic [31:0]            key32, wval32, pval32;

  assign in_stall = out_valid_r && out_stall && in_data.last;
  assign accept   = in_valid && !in_stall;
  assign finish   = accept && in_data.last;
  assign al       = align_code(in_data.ch);

  assign f_phase_in = (phase_r == PH_FIRST) ? PH_ALIGN : phase_r;

  fsp_feed #(
    .NUMBER_BITS(NUMBER_BITS)
  ) u_feed (
    .ch      (in_data.ch),
    .phase_i (f_phase_in),
    .flags_i (flags_r),
    .accum_i (acc_r),
    .wval_i  (wval_r),
    .pval_i  (pval_r),
    .phase_o (f_phase),
    .flags_o (f_flags),
    .accum_o (f_acc),
    .wval_o  (f_wval),
    .pval_o  (f_pval)
  );

  // state after this character
  always_comb begin
    s_phase = phase_r;
    s_pend  = pend_r;
    s_la    = la_r;
    s_flags = flags_r;
    s_acc   = acc_r;
    s_wval  = wval_r;
    s_pval  = pval_r;
    s_key   = key_r;
    case (phase_r)
      PH_KEY: begin
        if (in_data.ch == CH_COLON) begin
          s_phase = PH_FIRST;
        end else if (key_r != KEY_MAX) begin
          s_key = key_r + 1'b1;
        end
      end
      PH_FIRST: begin
        s_phase = f_phase;
        s_flags = f_flags;
        s_acc   = f_acc;
        s_wval  = f_wval;
        s_pval  = f_pval;
        s_pend  = 1'b1;
        s_la    = in_data.ch;
      end
      default: begin
        s_pend = 1'b0;
        if (pend_r && al != AL_NONE) begin
          // held character was a fill
          s_flags       = FLAGS_RESET;
          s_flags.fill  = la_r;
          s_flags.align = al;
          s_phase       = PH_SIGN;
          s_acc         = '0;
          s_wval        = '0;
          s_pval        = '0;
        end else begin
          s_phase = f_phase;
          s_flags = f_flags;
          s_acc   = f_acc;
          s_wval  = f_wval;
          s_pval  = f_pval;
        end
      end
    endcase
  end

  assign key32  = 32'(s_key);
  assign wval32 = 32'(s_wval);
  assign pval32 = 32'(s_pval);

  always_comb begin
    out_data_nxt.key_length    = (key32 > 32'd255) ? 8'hFF : key32[7:0];
    out_data_nxt.fill_char     = s_flags.fill;
    out_data_nxt.align_mode    = s_flags.align;
    out_data_nxt.sign_mode     = s_flags.sign;
    out_data_nxt.base_prefix   = s_flags.hash;
    out_data_nxt.width_mode    = s_flags.wmode;
    out_data_nxt.thousands_sep = s_flags.comma;
    out_data_nxt.precision_mode = s_flags.pmode;
    out_data_nxt.presentation  = s_flags.pres;
    out_data_nxt.error_code    = s_flags.err;
    if (s_flags.wmode == WM_DYN) begin
      out_data_nxt.width_value = '0;
    end else begin
      out_data_nxt.width_value = (wval32 > 32'd65535) ? 16'hFFFF : wval32[VALUE_W-1:0];
    end
    if (s_flags.pmode == PM_DOT_ONLY) begin
      out_data_nxt.precision_value = '0;
    end else begin
      out_data_nxt.precision_value = (pval32 > 32'd65535) ? 16'hFFFF
                                                          : pval32[VALUE_W-1:0];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    la_nxt    = la_r;
    flags_nxt = flags_r;
    acc_nxt   = acc_r;
    wval_nxt  = wval_r;
    pval_nxt  = pval_r;
    key_nxt   = key_r;
    if (finish) begin
      phase_nxt = PH_KEY;
      pend_nxt  = 1'b0;
      la_nxt    = '0;
      flags_nxt = FLAGS_RESET;
      acc_nxt   = '0;
      wval_nxt  = '0;
      pval_nxt  = '0;
      key_nxt   = '0;
    end else if (accept) begin
      phase_nxt = s_phase;
      pend_nxt  = s_pend;
      la_nxt    = s_la;
      flags_nxt = s_flags;
      acc_nxt   = s_acc;
      wval_nxt  = s_wval;
      pval_nxt  = s_pval;
      key_nxt   = s_key;
    end
    out_valid_nxt = finish || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_KEY;
      pend_r      <= 1'b0;
      la_r        <= '0;
      flags_r     <= FLAGS_RESET;
      acc_r       <= '0;
      wval_r      <= '0;
      pval_r      <= '0;
      key_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      pend_r      <= pend_nxt;
      la_r        <= la_nxt;
      flags_r     <= flags_nxt;
      acc_r       <= acc_nxt;
      wval_r      <= wval_nxt;
      pval_r      <= pval_nxt;
      key_r       <= key_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/fsp_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Format spec parser checker
// Port-level properties of the parser, bound to the top level.
// ----------------------------------------------------------------------------
module fsp_checker
  import fsp_pkg::*;
(
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_stall,
  input wire in_t  in_data,
  input wire logic out_valid,
  input wire logic out_stall,
  input wire out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("record changed while stalled");

  a_last_gives_record: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.last |=> out_valid)
    else $error("last request produced no record");

  a_record_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(out_valid && out_stall)
      |-> $past(in_valid && !in_stall && in_data.last))
    else $error("record without a last request");

  a_width_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.width_mode == WM_NONE || out_data.width_mode == WM_DYN)
      |-> out_data.width_value == '0)
    else $error("width value without width digits");

  a_prec_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.precision_mode == PM_NONE
                  || out_data.precision_mode == PM_DOT_ONLY)
      |-> out_data.precision_value == '0)
    else $error("precision value without precision digits");

endmodule

bind format_spec_parser fsp_checker u_fsp_checker (.*);
`default_nettype wire
